// ===== sv/streaming_fir_full_convolution_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the streaming FIR block.
// ----------------------------------------------------------------------------
`ifndef STREAMING_FIR_FULL_CONVOLUTION_ASSERT_SVH
`define STREAMING_FIR_FULL_CONVOLUTION_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define SFIR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SFIR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SFIR_ASSERT(lbl, prop, msg)
`define SFIR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/sfir_pkg.sv =====
// ----------------------------------------------------------------------------
// sfir_pkg
// Types and constants for the streaming transposed-form FIR filter.
// ----------------------------------------------------------------------------
package sfir_pkg;

    localparam int MAX_TAPS_DEF = 8;
    localparam int SAMPLE_W     = 16;
    localparam int COEFF_W      = 16;
    localparam int PROD_W       = SAMPLE_W + COEFF_W;
    localparam int VALUE_W      = 35;
    localparam int TAP_CNT_W    = 4;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_HIGH = 2'd2;

    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 4'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_signal;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      final_output;
    } t_out_item;

    // chain control, common to every cell
    typedef struct packed {
        logic advance;
        logic clear;
    } t_cell_ctrl;

endpackage

// ===== sv/sfir_cell.sv =====
// ----------------------------------------------------------------------------
// sfir_cell
// One tap of the transposed chain: holds a partial sum, adds its product.
// ----------------------------------------------------------------------------
`include "streaming_fir_full_convolution_assert.svh"

module sfir_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sfir_pkg::t_cell_ctrl                   i_ctrl,
    input  logic signed [sfir_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic signed [sfir_pkg::COEFF_W-1:0]    i_coeff,
    input  logic signed [sfir_pkg::VALUE_W-1:0]    i_sum_next,
    output logic signed [sfir_pkg::VALUE_W-1:0]    o_mac
);

    logic signed [sfir_pkg::VALUE_W-1:0] r_sum;
    logic signed [sfir_pkg::VALUE_W-1:0] n_sum;
    logic signed [sfir_pkg::PROD_W-1:0]  w_prod;

    assign w_prod = i_sample * i_coeff;
    assign o_mac  = {{(sfir_pkg::VALUE_W - sfir_pkg::PROD_W){w_prod[sfir_pkg::PROD_W-1]}},
                     w_prod} + r_sum;

    always_comb begin
        n_sum = r_sum;
        if (i_ctrl.advance) begin
            n_sum = i_ctrl.clear ? '0 : i_sum_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    `SFIR_ASSERT(a_cell_hold, !i_ctrl.advance |=> $stable(r_sum), "partial sum moved without advance")
    `SFIR_ASSERT(a_cell_clear, i_ctrl.advance && i_ctrl.clear |=> r_sum == '0, "partial sum not cleared")
    `SFIR_ASSERT_ALWAYS(a_cell_rst, !i_rst_n |=> r_sum == '0, "partial sum not zero after reset")

endmodule

// ===== sv/streaming_fir_full_convolution.sv =====
// ----------------------------------------------------------------------------
// streaming_fir_full_convolution
// Full linear convolution of a sample stream, transposed-form FIR, <= 8 taps.
// ----------------------------------------------------------------------------
// One sample is taken per clock while the input is not stalled. Each accepted
// sample produces its convolution output, which is registered into the output
// buffer. A sample marked end_of_signal is followed by tap_count-1 tail
// outputs, in which the chain shifts zeros through and emits the tail; the
// input is stalled during the tail and while the output buffer is full. A
// two-entry output buffer lets samples keep flowing while one result waits.
`include "streaming_fir_full_convolution_assert.svh"

module streaming_fir_full_convolution #(
    parameter int MAX_TAPS = sfir_pkg::MAX_TAPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  sfir_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output sfir_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [sfir_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sfir_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CNT_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TW    = sfir_pkg::TAP_CNT_W;
    localparam int VW    = sfir_pkg::VALUE_W;

    // configuration
    logic [TW-1:0]                     r_tap_count;
    logic [sfir_pkg::CFG_DATA_W-1:0]   r_coeff_low;
    logic [sfir_pkg::CFG_DATA_W-1:0]   r_coeff_high;
    logic [2*sfir_pkg::CFG_DATA_W-1:0] w_coeff_all;
    logic [TW-1:0]                     w_taps;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count  <= sfir_pkg::TAP_COUNT_RST;
            r_coeff_low  <= '0;
            r_coeff_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sfir_pkg::REG_TAP_COUNT:  r_tap_count  <= i_cfg_data[TW-1:0];
                sfir_pkg::REG_COEFF_LOW:  r_coeff_low  <= i_cfg_data;
                sfir_pkg::REG_COEFF_HIGH: r_coeff_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_taps = r_tap_count;
        if (r_tap_count == '0) begin
            w_taps = TW'(1);
        end else if (r_tap_count > TW'(MAX_TAPS)) begin
            w_taps = TW'(MAX_TAPS);
        end
    end

    assign w_coeff_all = {r_coeff_high, r_coeff_low};

    // flush control and output buffer
    logic [CNT_W-1:0]        r_flush_left;
    logic [CNT_W-1:0]        n_flush_left;
    logic                    w_flushing;
    logic                    w_full;
    logic                    w_in_acc;
    logic                    w_push;
    logic                    w_pop;
    logic                    w_last;
    logic                    w_eos_multi;
    sfir_pkg::t_cell_ctrl    w_ctrl;
    logic signed [sfir_pkg::SAMPLE_W-1:0] w_x;
    logic signed [VW-1:0]    w_mac [MAX_TAPS];

    logic [1:0]              r_count;
    logic [1:0]              n_count;
    sfir_pkg::t_out_item     r_out;
    sfir_pkg::t_out_item     n_out;
    sfir_pkg::t_out_item     r_skid;
    sfir_pkg::t_out_item     n_skid;
    sfir_pkg::t_out_item     w_new;

    assign w_flushing  = (r_flush_left != '0);
    assign w_full      = (r_count == 2'd2);
    assign o_in_stall  = w_full || w_flushing;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_push      = !w_full && (w_in_acc || w_flushing);
    assign w_pop       = o_out_valid && !i_out_stall;
    assign w_eos_multi = i_in_data.end_of_signal && (w_taps != TW'(1));

    // last output of the convolution: end of tail, or a single-tap end sample
    assign w_last = w_flushing ? (r_flush_left == CNT_W'(1))
                               : (i_in_data.end_of_signal && (w_taps == TW'(1)));

    assign w_x            = w_flushing ? '0 : i_in_data.sample;
    assign w_ctrl.advance = w_push;
    assign w_ctrl.clear   = w_last;

    always_comb begin
        n_flush_left = r_flush_left;
        if (w_push) begin
            if (w_flushing) begin
                n_flush_left = r_flush_left - CNT_W'(1);
            end else if (w_eos_multi) begin
                n_flush_left = CNT_W'(w_taps - TW'(1));
            end
        end
    end

    assign w_new.value        = w_mac[0];
    assign w_new.final_output = w_last;

    always_comb begin
        n_count = r_count;
        n_out   = r_out;
        n_skid  = r_skid;
        case (r_count)
            2'd0: begin
                if (w_push) begin
                    n_out   = w_new;
                    n_count = 2'd1;
                end
            end
            2'd1: begin
                if (w_push && w_pop) begin
                    n_out = w_new;
                end else if (w_pop) begin
                    n_count = 2'd0;
                end else if (w_push) begin
                    n_skid  = w_new;
                    n_count = 2'd2;
                end
            end
            default: begin
                if (w_pop) begin
                    n_out   = r_skid;
                    n_count = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush_left <= '0;
            r_count      <= '0;
        end else begin
            r_flush_left <= n_flush_left;
            r_count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = (r_count != 2'd0);
    assign o_out_data  = r_out;

    // chain of cells: cell j multiplies by coefficient j, takes cell j+1's sum
    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        logic signed [sfir_pkg::COEFF_W-1:0] w_coeff;
        logic signed [VW-1:0]                w_next;

        assign w_coeff = (TW'(j) < w_taps)
                       ? w_coeff_all[j*sfir_pkg::COEFF_W +: sfir_pkg::COEFF_W] : '0;

        if (j == MAX_TAPS - 1) begin : g_top
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_mac[j+1];
        end

        sfir_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_sample   (w_x),
            .i_coeff    (w_coeff),
            .i_sum_next (w_next),
            .o_mac      (w_mac[j])
        );
    end

    `SFIR_ASSERT(a_flush_stalls, w_flushing |-> o_in_stall, "input taken during tail flush")
    `SFIR_ASSERT(a_full_stalls, w_full |-> !w_push, "result pushed into a full buffer")
    `SFIR_ASSERT(a_final_ends, w_push && w_last |=> r_flush_left == '0, "flush outlived final output")
    `SFIR_ASSERT(a_flush_start, w_in_acc && w_eos_multi |=> w_flushing, "tail flush did not start")

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming transposed-form FIR convolver.
// ----------------------------------------------------------------------------
// Samples are pushed through the valid/stall input with random gaps while the
// output side stalls at random. A scoreboard class keeps its own copy of the
// coefficient registers and the partial-sum chain. It works out every output
// of each accepted sample, tail flushes included, and checks each output
// transaction against the oldest one it holds. Registers are rewritten between
// phases only once the block has drained.
module tb;
    import sfir_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RAND_ITEMS   = 260;

    class conv_checker;
        logic [TAP_CNT_W-1:0]  taps_reg;
        logic [CFG_DATA_W-1:0] coeff_lo;
        logic [CFG_DATA_W-1:0] coeff_hi;
        longint                chain[8];
        t_out_item             conv_outputs_q[$];
        int                    errors;

        function new();
            taps_reg = TAP_COUNT_RST;
            coeff_lo = '0;
            coeff_hi = '0;
            errors   = 0;
            foreach (chain[i]) chain[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TAP_COUNT:  taps_reg = data[TAP_CNT_W-1:0];
                REG_COEFF_LOW:  coeff_lo = data;
                REG_COEFF_HIGH: coeff_hi = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return conv_outputs_q.size();
        endfunction

        // one sample through the chain, plus the tail on end of signal
        function void note_sample(t_in_item it);
            int                       taps;
            longint                   x;
            longint                   c[8];
            longint                   y;
            logic [2*CFG_DATA_W-1:0]  all_coeffs;
            logic signed [COEFF_W-1:0] cf;
            t_out_item                o;
            taps = (taps_reg == 0) ? 1 : (taps_reg > 8) ? 8 : int'(taps_reg);
            all_coeffs = {coeff_hi, coeff_lo};
            x = it.sample;
            for (int k = 0; k < 8; k++) begin
                cf = all_coeffs[16*k +: 16];
                c[k] = (k < taps) ? longint'(cf) : 0;
            end
            y = x * c[0] + chain[0];
            for (int i = 0; i < 7; i++) chain[i] = x * c[i+1] + chain[i+1];
            chain[7] = 0;
            o.value = y[VALUE_W-1:0];
            o.final_output = it.end_of_signal && (taps == 1);
            conv_outputs_q.push_back(o);
            if (it.end_of_signal) begin
                for (int k = 1; k < taps; k++) begin
                    o.value = chain[0][VALUE_W-1:0];
                    o.final_output = (k + 1 == taps);
                    conv_outputs_q.push_back(o);
                    for (int i = 0; i < 7; i++) chain[i] = chain[i+1];
                    chain[7] = 0;
                end
                foreach (chain[i]) chain[i] = 0;
            end
        endfunction

        function void check_output(t_out_item got);
            t_out_item want;
            if (conv_outputs_q.size() == 0) begin
                $error("unexpected output transaction: value %0d final %0b",
                       got.value, got.final_output);
                errors++;
                return;
            end
            want = conv_outputs_q.pop_front();
            if (got.value !== want.value) begin
                $error("value: expected %0d, got %0d", want.value, got.value);
                errors++;
            end
            if (got.final_output !== want.final_output) begin
                $error("final_output: expected %0b, got %0b",
                       want.final_output, got.final_output);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              in_data = '0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    conv_checker chk = new();
    int          in_idle_pct = 25;
    int          out_idle_pct = 25;
    int          samples_sent = 0;
    int          cycles = 0;

    streaming_fir_full_convolution DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // pre-edge values are sampled here, so acceptance matches the DUT's view
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !o_in_stall) chk.note_sample(in_data);
        if (i_rst_n && o_out_valid && !out_stall) chk.check_output(o_out_data);
    end

    task automatic send(logic signed [SAMPLE_W-1:0] s, logic eos);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in_item'{sample: s, end_of_signal: eos};
        do @(posedge i_clk); while (o_in_stall);
        samples_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        chk.set_reg(idx, data);
    endtask

    // one edge first, so the last accepted sample is already in the scoreboard
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(logic [TAP_CNT_W-1:0] taps, logic [CFG_DATA_W-1:0] lo,
                             logic [CFG_DATA_W-1:0] hi);
        drain();
        write_reg(REG_TAP_COUNT, CFG_DATA_W'(taps));
        write_reg(REG_COEFF_LOW, lo);
        write_reg(REG_COEFF_HIGH, hi);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_coeffs();
        case ($urandom_range(7))
            0:       return {4{16'h8000}};
            1:       return {4{16'h7FFF}};
            2:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int phase;
        int n_sig;
        int len;
        logic [TAP_CNT_W-1:0] taps;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: one tap, zero coefficient, end of signal on a lone sample
        send(16'sh7FFF, 1'b1);

        configure(4'd8, 64'h8000_7FFF_8000_7FFF, 64'h7FFF_8000_0001_FFFF);
        send(-16'sd32768, 1'b0);
        send(16'sd32767, 1'b0);
        send(16'sd0, 1'b0);
        send(-16'sd1, 1'b0);
        send(16'sd1, 1'b1);

        // zero taps acts as one; upper coefficients must be ignored
        configure(4'd0, 64'h0000_0000_0000_8000, '1);
        send(-16'sd32768, 1'b1);
        send(16'sd32767, 1'b1);

        // above the maximum acts as eight; largest possible sum
        configure(4'd15, {4{16'h8000}}, {4{16'h8000}});
        repeat (8) send(-16'sd32768, 1'b0);
        send(-16'sd32768, 1'b1);

        // tap count cut in mid-signal
        configure(4'd4, 64'h1234_C000_4000_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
        send(16'sd12345, 1'b0);
        send(-16'sd20000, 1'b0);
        send(16'sd32767, 1'b0);
        configure(4'd2, 64'h1234_C000_4000_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
        send(16'sd1000, 1'b0);
        send(-16'sd32768, 1'b1);

        samples_sent = 0;
        phase = 0;
        while (samples_sent < RAND_ITEMS) begin
            if ($urandom_range(4) == 0) taps = 4'($urandom_range(15));
            else taps = 4'($urandom_range(8, 1));
            configure(taps, rand_coeffs(), rand_coeffs());
            // a quiet stretch on both sides through the middle phases
            in_idle_pct  = (phase >= 5 && phase < 9) ? 0 : 25;
            out_idle_pct = in_idle_pct;
            n_sig = $urandom_range(4, 1);
            for (int s = 0; s < n_sig; s++) begin
                len = $urandom_range(10, 1);
                for (int j = 0; j < len; j++) begin
                    if ($urandom_range(9) == 0)
                        send(SAMPLE_W'($urandom), 1'($urandom));
                    else
                        send(SAMPLE_W'($urandom), j == len - 1);
                end
            end
            phase++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/sfir_pkg.sv
sv/sfir_cell.sv
sv/streaming_fir_full_convolution.sv
tb/sv/tb.sv
